>>> sv/fm_polar_discriminator_assert.svh
// Assertion macros for the FM polar discriminator.
// Each macro samples on the rising edge of clk; the first one is disabled
// while arst_n is low, the second one also checks during reset.
`ifndef FM_POLAR_DISCRIMINATOR_ASSERT_SVH
`define FM_POLAR_DISCRIMINATOR_ASSERT_SVH

`define FMPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define FMPD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fmpd_pkg.sv
`timescale 1ns / 1ps

package fmpd_pkg;

	// angle accumulator width, pi = 2^31
	localparam int Z_W = 34;

	// arctangent table, atan(2^-i) with pi = 2^31
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W = 5;

	typedef logic [31:0] atan_word_t;

	localparam atan_word_t ATAN_TABLE [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(1073741824);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_ROT,
		ST_ITER,
		ST_OUT
	} state_t;

	// operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_RR,
		MUL_II,
		MUL_IR,
		MUL_RI
	} mul_sel_t;

	// what to do with the registered product
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD_X,
		ACC_ADD_X,
		ACC_LOAD_Y,
		ACC_SUB_Y
	} acc_op_t;

	typedef struct packed {
		logic                  load_in;
		mul_sel_t              mul_sel;
		acc_op_t               acc_op;
		logic                  rotate;
		logic                  iterate;
		logic [ATAN_IDX_W-1:0] step;
		logic                  load_out;
		logic                  zero_out;
	} dp_cmd_t;

	typedef struct packed {
		logic prod_zero;
	} dp_stat_t;

endpackage

>>> sv/fmpd_ctrl.sv
`timescale 1ns / 1ps

module fmpd_ctrl import fmpd_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

	state_t        state_q, state_d;
	logic [1:0]    mul_cnt_q;
	logic [IW-1:0] iter_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_cnt_q == 2'd3) state_d = ST_ACC;
			end
			ST_ACC:  state_d = ST_ROT;
			ST_ROT:  state_d = ST_ITER;
			ST_ITER: begin
				if (iter_q == LAST_STEP) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_RR;
		cmd.acc_op   = ACC_NONE;
		cmd.step     = ATAN_IDX_W'(iter_q);
		cmd.zero_out = stat.prod_zero;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_MUL: begin
				cmd.mul_sel = mul_sel_t'(mul_cnt_q);
				case (mul_cnt_q)
					2'd1:    cmd.acc_op = ACC_LOAD_X;
					2'd2:    cmd.acc_op = ACC_ADD_X;
					2'd3:    cmd.acc_op = ACC_LOAD_Y;
					default: cmd.acc_op = ACC_NONE;
				endcase
			end
			ST_ACC:  cmd.acc_op = ACC_SUB_Y;
			ST_ROT:  cmd.rotate = 1'b1;
			ST_ITER: cmd.iterate = 1'b1;
			ST_OUT:  cmd.load_out = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	// hold state, counters and the result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_cnt_q   <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) mul_cnt_q <= mul_cnt_q + 2'd1;
			else mul_cnt_q <= '0;
			if (state_q == ST_ITER) iter_q <= iter_q + IW'(1);
			else iter_q <= '0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/fmpd_datapath.sv
`timescale 1ns / 1ps

module fmpd_datapath import fmpd_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample_real,
	input  logic signed [SAMPLE_BITS-1:0] sample_imag,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	output logic signed [ANGLE_BITS-1:0]  phase_step
);

	localparam int PW = 2 * SAMPLE_BITS;
	localparam int CW = 2 * SAMPLE_BITS + 4;
	localparam int RND_SH = 32 - ANGLE_BITS;
	localparam logic signed [Z_W-1:0] RND = Z_W'(64'sd1 <<< (RND_SH - 1));
	localparam logic signed [Z_W-1:0] ANG_MAX = Z_W'((64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1);
	localparam logic signed [Z_W-1:0] ANG_MIN = ~ANG_MAX;

	logic signed [SAMPLE_BITS-1:0] cur_real_q, cur_imag_q;
	logic signed [SAMPLE_BITS-1:0] prev_real_q, prev_imag_q;
	logic signed [SAMPLE_BITS-1:0] mul_a, mul_b;
	logic signed [PW-1:0]          prod_q;
	logic signed [CW-1:0]          prod_ext;
	logic signed [CW-1:0]          x_q, y_q;
	logic signed [CW-1:0]          x_sh, y_sh;
	logic signed [Z_W-1:0]         z_q;
	logic signed [Z_W-1:0]         tab;
	logic signed [Z_W-1:0]         z_rnd, z_shr, z_sat;
	logic                          zero_q;
	logic signed [ANGLE_BITS-1:0]  phase_q;

	// hold current and previous sample; both clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_real_q  <= '0;
			cur_imag_q  <= '0;
			prev_real_q <= '0;
			prev_imag_q <= '0;
		end else if (cmd.load_in) begin
			prev_real_q <= cur_real_q;
			prev_imag_q <= cur_imag_q;
			cur_real_q  <= sample_real;
			cur_imag_q  <= sample_imag;
		end
	end

	// select multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_RR: begin mul_a = cur_real_q; mul_b = prev_real_q; end
			MUL_II: begin mul_a = cur_imag_q; mul_b = prev_imag_q; end
			MUL_IR: begin mul_a = cur_imag_q; mul_b = prev_real_q; end
			MUL_RI: begin mul_a = cur_real_q; mul_b = prev_imag_q; end
			default: begin mul_a = cur_real_q; mul_b = prev_real_q; end
		endcase
	end

	assign prod_ext = CW'(prod_q);
	assign x_sh     = x_q >>> cmd.step;
	assign y_sh     = y_q >>> cmd.step;
	assign tab      = Z_W'(ATAN_TABLE[cmd.step]);

	// multiply, accumulate the product, pre-rotate and iterate CORDIC
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LOAD_X: x_q <= prod_ext;
			ACC_ADD_X:  x_q <= x_q + prod_ext;
			ACC_LOAD_Y: y_q <= prod_ext;
			ACC_SUB_Y:  y_q <= y_q - prod_ext;
			default: ;
		endcase
		if (cmd.rotate) begin
			zero_q <= (x_q == '0) && (y_q == '0);
			if (x_q[CW-1]) begin
				if (!y_q[CW-1]) begin
					x_q <= y_q;
					y_q <= -x_q;
					z_q <= Z_HALF_PI;
				end else begin
					x_q <= -y_q;
					y_q <= x_q;
					z_q <= -Z_HALF_PI;
				end
			end else begin
				z_q <= '0;
			end
		end
		if (cmd.iterate) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - tab;
			end
		end
	end

	// round half up, then saturate to the output range
	always_comb begin
		z_rnd = z_q + RND;
		z_shr = z_rnd >>> RND_SH;
		if (z_shr > ANG_MAX) z_sat = ANG_MAX;
		else if (z_shr < ANG_MIN) z_sat = ANG_MIN;
		else z_sat = z_shr;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			phase_q <= cmd.zero_out ? '0 : ANGLE_BITS'(z_sat);
		end
	end

	assign stat.prod_zero = zero_q;
	assign phase_step     = phase_q;

endmodule

>>> sv/fm_polar_discriminator.sv
`timescale 1ns / 1ps
// FM polar discriminator.
// Input channel: sample_real/sample_imag with in_valid/in_stall. A beat is
// taken when in_valid is high and in_stall low. Output channel: phase_step
// with out_valid/out_stall; the angle of sample * conj(previous sample) in
// units of pi / 2^(ANGLE_BITS-1), +pi saturated, zero product gives 0.
// One shared multiplier forms the four partial products of the complex
// product, then a pre-rotation step and CORDIC_STEPS steps run the iterated
// vectoring CORDIC, one step per cycle through a single add/shift unit.
// No new beat is taken until the current one is finished; in_stall is high
// while a beat is in work.
// A finished result waits in the output register while the next beat is
// accepted; if the receiver still stalls when the next result is ready, the
// block holds in its final step until the register frees.
// Reset clears the previous sample to zero, so the first result is 0, and
// empties the output register.
module fm_polar_discriminator import fmpd_pkg::*; #(
	parameter int SAMPLE_BITS  = 16,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_real,
	input  logic signed [SAMPLE_BITS-1:0] sample_imag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ANGLE_BITS-1:0]  phase_step
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fmpd_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	fmpd_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.cmd         (cmd),
		.stat        (stat),
		.phase_step  (phase_step)
	);

endmodule

>>> sv/fmpd_checker.sv
`timescale 1ns / 1ps
`include "fm_polar_discriminator_assert.svh"

module fmpd_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [ANGLE_BITS-1:0] phase_step
);

	// a taken beat closes the input side
	`FMPD_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "no stall after beat")

	// a new result comes only from a beat that was in work
	`FMPD_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result from nothing")

	// a stalled result holds
	`FMPD_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(phase_step), "result moved")

	// reset empties the output register
	`FMPD_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "result during reset")

endmodule

bind fm_polar_discriminator fmpd_checker #(
	.ANGLE_BITS(ANGLE_BITS)
) u_fmpd_checker (.*);
